// ----- sv/hufd_pkg.sv -----
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and constants for the Huffman tree-walk decoder: node layout,
// command and result words, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package hufd_pkg;

    localparam int DEFAULT_MAX_NODES = 512;
    localparam int BYTE_BITS         = 8;
    localparam int TOP_BIT           = 7;
    localparam int NODE_W            = 27;

    // Operation codes carried in the command word
    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    // One stored tree node
    typedef struct packed
    {
        logic       leaf;
        logic [7:0] symbol;
        logic [8:0] left;
        logic [8:0] right;
    } node_t;

    // Command word
    typedef struct packed
    {
        op_t        op;
        logic [8:0] node_index;
        logic       node_is_leaf;
        logic [7:0] node_symbol;
        logic [8:0] left_child;
        logic [8:0] right_child;
        logic [7:0] data_byte;
        logic [3:0] valid_bits;
    } cmd_t;

    // Result word
    typedef struct packed
    {
        logic [7:0] symbol;
        logic       last;
    } result_t;

    // Walk sequencer states
    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_ROOT,
        ST_STEP,
        ST_FLUSH
    } state_t;

endpackage

// ----- sv/huffman_tree_bit_decoder.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder
// Huffman decoder walking a code tree held in a node table RAM.
// ----------------------------------------------------------------------------
// A write word (op 0) stores one node and busy stays low.
// A decode word (op 1) keeps busy high through the root, step and flush
// states, with valid_bits capped at eight: the root state reads the root,
// then each bit takes a step as it needs the previous node-table read, a
// further step settles the last read, and the flush releases the last symbol.
// Symbols leave on strobe one cycle each and cannot be stalled; last marks
// the final symbol of a byte. The walk position carries across bytes and
// returns to the root after every node write. Reading a slot never written
// is undefined.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder #(
    parameter int MAX_NODES = hufd_pkg::DEFAULT_MAX_NODES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  hufd_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              strobe,
    output hufd_pkg::result_t result
);
    import hufd_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    node_t         mem_wdata;
    node_t         mem_rdata;

    // Walk sequencer
    hufd_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .strobe    (strobe),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Node table
    hufd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- sv/hufd_ram.sv -----
// ----------------------------------------------------------------------------
// hufd_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hufd_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/hufd_ctrl.sv -----
// ----------------------------------------------------------------------------
// hufd_ctrl
// Tree-walk sequencer: takes command words, writes nodes, steps through the
// node table one bit per cycle and emits symbols one symbol behind so that the
// final symbol of a byte can be flagged.
// ----------------------------------------------------------------------------
module hufd_ctrl #(
    parameter int MAX_NODES = hufd_pkg::DEFAULT_MAX_NODES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  hufd_pkg::cmd_t               cmd,
    output logic                         busy,
    output logic                         strobe,
    output hufd_pkg::result_t            result,
    output logic                         mem_we,
    output logic [$clog2(MAX_NODES)-1:0] mem_waddr,
    output hufd_pkg::node_t              mem_wdata,
    output logic [$clog2(MAX_NODES)-1:0] mem_raddr,
    input  hufd_pkg::node_t              mem_rdata
);
    import hufd_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    state_t          state_reg, state_next;
    logic [AW-1:0]   walk_reg, walk_next;
    node_t           cur_reg, cur_next;
    node_t           root_reg, root_next;
    logic            rd_pend_reg, rd_pend_next;
    logic [7:0]      byte_reg, byte_next;
    logic [3:0]      bits_reg, bits_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [7:0]      pend_sym_reg, pend_sym_next;

    logic            accept;
    logic            have_bit;
    logic            arrive_leaf;
    node_t           node_eff;
    logic [AW-1:0]   pos_eff;
    logic [8:0]      child;
    logic            child_oob;
    logic            emit;
    logic [7:0]      emit_sym;

    assign accept = start && (state_reg == ST_IDLE);

    // Resolve the node in flight and pick the child for the current bit
    always_comb
    begin
        have_bit    = (bits_reg != 4'd0);
        arrive_leaf = rd_pend_reg && mem_rdata.leaf;
        if (arrive_leaf)
        begin
            node_eff = root_reg;
            pos_eff  = '0;
        end
        else if (rd_pend_reg)
        begin
            node_eff = mem_rdata;
            pos_eff  = walk_reg;
        end
        else
        begin
            node_eff = cur_reg;
            pos_eff  = walk_reg;
        end
        child     = byte_reg[TOP_BIT] ? node_eff.right : node_eff.left;
        child_oob = (int'(child) >= MAX_NODES);
        emit      = 1'b0;
        emit_sym  = mem_rdata.symbol;
        if (state_reg == ST_STEP)
        begin
            if (root_reg.leaf && have_bit)
            begin
                emit     = 1'b1;
                emit_sym = root_reg.symbol;
            end
            else if (arrive_leaf)
            begin
                emit = 1'b1;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.op == OP_DECODE))
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:  state_next = ST_STEP;
            ST_STEP:
            begin
                if (!have_bit)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Walk datapath updates
    always_comb
    begin
        walk_next       = walk_reg;
        cur_next        = cur_reg;
        root_next       = root_reg;
        rd_pend_next    = 1'b0;
        byte_next       = byte_reg;
        bits_next       = bits_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.op == OP_WRITE)
                    begin
                        walk_next = '0;
                    end
                    else
                    begin
                        byte_next       = cmd.data_byte;
                        bits_next       = (cmd.valid_bits > 4'(BYTE_BITS)) ?
                                          4'(BYTE_BITS) : cmd.valid_bits;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            ST_ROOT:
            begin
                // Latch the root; the current node is the root when at slot 0
                root_next = mem_rdata;
                if (walk_reg == '0)
                begin
                    cur_next = mem_rdata;
                end
            end
            ST_STEP:
            begin
                if (root_reg.leaf)
                begin
                    if (have_bit)
                    begin
                        walk_next = '0;
                        cur_next  = root_reg;
                        byte_next = {byte_reg[TOP_BIT-1:0], 1'b0};
                        bits_next = bits_reg - 4'd1;
                    end
                end
                else if (have_bit)
                begin
                    byte_next = {byte_reg[TOP_BIT-1:0], 1'b0};
                    bits_next = bits_reg - 4'd1;
                    if (child_oob)
                    begin
                        walk_next = '0;
                        cur_next  = root_reg;
                    end
                    else
                    begin
                        walk_next    = AW'(child);
                        rd_pend_next = 1'b1;
                    end
                end
                else
                begin
                    walk_next = pos_eff;
                    cur_next  = node_eff;
                end
                if (emit)
                begin
                    pend_valid_next = 1'b1;
                    pend_sym_next   = emit_sym;
                end
            end
            ST_FLUSH:
            begin
                pend_valid_next = 1'b0;
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    // Handshake, result word and memory ports
    always_comb
    begin
        busy          = (state_reg != ST_IDLE);
        strobe        = pend_valid_reg && (emit || (state_reg == ST_FLUSH));
        result.symbol = pend_sym_reg;
        result.last   = (state_reg == ST_FLUSH);
        mem_we        = accept && (cmd.op == OP_WRITE) && (int'(cmd.node_index) < MAX_NODES);
        mem_waddr     = AW'(cmd.node_index);
        mem_wdata     = '{leaf:   cmd.node_is_leaf,
                          symbol: cmd.node_symbol,
                          left:   cmd.left_child,
                          right:  cmd.right_child};
        mem_raddr     = (state_reg == ST_STEP) ? AW'(child) : '0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            walk_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            bits_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            walk_reg       <= walk_next;
            rd_pend_reg    <= rd_pend_next;
            bits_reg       <= bits_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        root_reg     <= root_next;
        byte_reg     <= byte_next;
        pend_sym_reg <= pend_sym_next;
    end

    // Checks
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result strobe outside a decode");

    a_pend_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == ST_STEP))
        else $error("node read in flight outside the step state");

    a_write_resets_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.op == OP_WRITE)) |=> (walk_reg == '0))
        else $error("walk not back at root after a node write");

    a_flush_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |=> !pend_valid_reg)
        else $error("held symbol survives the flush");

    a_leaf_root_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_STEP) && root_reg.leaf) |-> !rd_pend_reg)
        else $error("node read in flight with a one-leaf tree");

endmodule

// ----- tb/sv/tb_huffman_tree_bit_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_bit_decoder
// Self-checking bench for the Huffman tree-walk decoder. It loads random code
// trees into the node table one word at a time and feeds compressed bytes
// with random bit counts. Small trees, codes that span bytes, one-leaf trees
// and node writes made in the middle of a walk are all covered. A walk
// predictor inside a scoreboard works out the symbols each word must yield,
// and every strobed result is compared with the oldest symbol still waiting.
// Every walk stays on nodes that have been written.
// ----------------------------------------------------------------------------
module tb_huffman_tree_bit_decoder;

    import hufd_pkg::*;

    localparam int TOTAL_WORDS  = 320;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the node table and walk position, and holds the
    // symbols still owed by the block
    // ------------------------------------------------------------------------
    class symbol_scoreboard;
        node_t      node_table [DEFAULT_MAX_NODES];
        logic [8:0] walk;
        result_t    owed_symbols [$];
        int         errors;

        function new();
            foreach (node_table[i])
                node_table[i] = '0;
            walk   = '0;
            errors = 0;
        endfunction

        // Walk the bits of an accepted decode word, or store an accepted node
        function void note_word(cmd_t w);
            result_t    found [$];
            node_t      root;
            node_t      cur;
            node_t      nxt;
            logic [8:0] next_slot;
            int         nbits;
            if (w.op == OP_WRITE)
            begin
                if (int'(w.node_index) < DEFAULT_MAX_NODES)
                    node_table[w.node_index] =
                        '{w.node_is_leaf, w.node_symbol, w.left_child, w.right_child};
                walk = '0;
                return;
            end
            nbits = int'(w.valid_bits);
            if (nbits > BYTE_BITS)
                nbits = BYTE_BITS;
            root = node_table[0];
            for (int i = 0; i < nbits; i++)
            begin
                // One-leaf tree: every bit yields the root symbol
                if (root.leaf)
                begin
                    walk = '0;
                    found.push_back('{root.symbol, 1'b0});
                    continue;
                end
                cur       = node_table[walk];
                next_slot = w.data_byte[TOP_BIT - i] ? cur.right : cur.left;
                // Child outside the table: drop the bit and return to the root
                if (int'(next_slot) >= DEFAULT_MAX_NODES)
                begin
                    walk = '0;
                    continue;
                end
                nxt = node_table[next_slot];
                if (nxt.leaf)
                begin
                    found.push_back('{nxt.symbol, 1'b0});
                    walk = '0;
                end
                else
                    walk = next_slot;
            end
            if (found.size() > 0)
                found[found.size() - 1].last = 1'b1;
            foreach (found[i])
                owed_symbols.push_back(found[i]);
        endfunction

        // Compare one strobed result with the oldest owed symbol
        function void check_symbol(result_t got);
            result_t want;
            if (owed_symbols.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: unexpected result symbol=%02h last=%0b",
                             $realtime, got.symbol, got.last);
                return;
            end
            want = owed_symbols.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: expected symbol=%02h last=%0b, got symbol=%02h last=%0b",
                             $realtime, want.symbol, want.last, got.symbol, got.last);
            end
        endfunction

        // Count symbols that never arrived
        function void close_out();
            if (owed_symbols.size() != 0)
            begin
                errors += owed_symbols.size();
                $display("%0d expected symbols never arrived", owed_symbols.size());
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    cmd_t    cmd;
    logic    busy;
    logic    strobe;
    result_t result;

    symbol_scoreboard board = new();

    int  cycles;
    int  words_sent;
    bit  written   [DEFAULT_MAX_NODES];
    int  written_slots [$];
    bit  in_tree   [DEFAULT_MAX_NODES];
    node_t tree_node [DEFAULT_MAX_NODES];

    huffman_tree_bit_decoder dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    // Clock, 8 ns period
    initial
        clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sample results first, then the accepted word, at each rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                board.check_symbol(result);
            if (start && !busy)
                board.note_word(cmd);
        end
    end

    // Build a word with every field random, then fix the operation
    function automatic cmd_t random_word(op_t op);
        cmd_t w;
        w.op           = op;
        w.node_index   = 9'($urandom_range(511, 0));
        w.node_is_leaf = 1'($urandom_range(1, 0));
        w.node_symbol  = 8'($urandom_range(255, 0));
        w.left_child   = 9'($urandom_range(511, 0));
        w.right_child  = 9'($urandom_range(511, 0));
        w.data_byte    = 8'($urandom_range(255, 0));
        w.valid_bits   = 4'($urandom_range(15, 0));
        return w;
    endfunction

    function automatic node_t random_leaf();
        node_t nd;
        nd.leaf   = 1'b1;
        nd.symbol = 8'($urandom_range(255, 0));
        nd.left   = 9'($urandom_range(511, 0));
        nd.right  = 9'($urandom_range(511, 0));
        return nd;
    endfunction

    // Present one word and hold it until accepted; call at a falling edge
    task automatic send_word(cmd_t w);
        bit quiet;
        quiet = (words_sent >= 140) && (words_sent < 220);
        if (!quiet && ($urandom_range(99, 0) < 17))
        begin
            start = 1'b0;
            cmd   = random_word(op_t'($urandom_range(1, 0)));
            repeat ($urandom_range(5, 1)) @(negedge clk);
        end
        cmd   = w;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_node(int slot, node_t nd);
        cmd_t w;
        w              = random_word(OP_WRITE);
        w.node_index   = 9'(slot);
        w.node_is_leaf = nd.leaf;
        w.node_symbol  = nd.symbol;
        w.left_child   = nd.left;
        w.right_child  = nd.right;
        send_word(w);
        if (!written[slot])
        begin
            written[slot] = 1'b1;
            written_slots.push_back(slot);
        end
    endtask

    task automatic send_byte(logic [7:0] data, logic [3:0] count);
        cmd_t w;
        w            = random_word(OP_DECODE);
        w.data_byte  = data;
        w.valid_bits = count;
        send_word(w);
    endtask

    // Claim an unused slot for the tree being built
    function automatic int fresh_slot();
        int s;
        do
            s = $urandom_range(511, 1);
        while (in_tree[s]);
        in_tree[s] = 1'b1;
        return s;
    endfunction

    // Grow a random tree by splitting leaves, then load it in shuffled order
    task automatic load_tree(int leaf_total);
        int host_q [$];
        int order [$];
        int pick;
        int host;
        int tmp;
        int j;
        foreach (in_tree[i])
            in_tree[i] = 1'b0;
        in_tree[0]   = 1'b1;
        tree_node[0] = random_leaf();
        host_q.push_back(0);
        for (int k = 1; k < leaf_total; k++)
        begin
            pick = $urandom_range(host_q.size() - 1, 0);
            host = host_q[pick];
            host_q.delete(pick);
            tree_node[host].leaf  = 1'b0;
            tree_node[host].left  = 9'(fresh_slot());
            tree_node[host].right = 9'(fresh_slot());
            tree_node[tree_node[host].left]  = random_leaf();
            tree_node[tree_node[host].right] = random_leaf();
            host_q.push_back(int'(tree_node[host].left));
            host_q.push_back(int'(tree_node[host].right));
        end
        for (int s = 0; s < DEFAULT_MAX_NODES; s++)
            if (in_tree[s])
                order.push_back(s);
        for (int k = order.size() - 1; k > 0; k--)
        begin
            j        = $urandom_range(k, 0);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        foreach (order[k])
            send_node(order[k], tree_node[order[k]]);
    endtask

    // Overwrite any slot with a leaf, or an inner node over written slots
    task automatic send_stray_node();
        node_t nd;
        nd = random_leaf();
        if ($urandom_range(1, 0))
        begin
            nd.leaf  = 1'b0;
            nd.left  = 9'(written_slots[$urandom_range(written_slots.size() - 1, 0)]);
            nd.right = 9'(written_slots[$urandom_range(written_slots.size() - 1, 0)]);
        end
        send_node($urandom_range(511, 0), nd);
    endtask

    // Mostly full bytes, some short ones, a few empty or oversized counts
    function automatic logic [3:0] random_count();
        int r;
        r = $urandom_range(19, 0);
        if (r == 0)
            return 4'd0;
        if (r == 1)
            return 4'($urandom_range(15, 9));
        if (r < 5)
            return 4'($urandom_range(7, 1));
        return 4'd8;
    endfunction

    initial
    begin
        int leaf_total;
        int r;
        node_t nd;
        start      = 1'b0;
        cmd        = '0;
        rst_n      = 1'b0;
        cycles     = 0;
        words_sent = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // One-leaf tree: each bit yields the root symbol
        nd = '{1'b1, 8'hFF, 9'h1FF, 9'h1FF};
        send_node(0, nd);
        send_byte(8'hA5, 4'd8);
        send_byte(8'h3C, 4'd0);
        send_byte(8'h00, 4'd15);
        send_byte(8'hFF, 4'd1);

        // Three-symbol code: 0 -> 00, 10 -> 80, 11 -> 7F
        send_node(511, '{1'b1, 8'h00, 9'h000, 9'h1FF});
        send_node(256, '{1'b1, 8'h80, 9'h0AA, 9'h155});
        send_node(2,   '{1'b1, 8'h7F, 9'h100, 9'h0FF});
        send_node(1,   '{1'b0, 8'h55, 9'd256, 9'd2});
        send_node(0,   '{1'b0, 8'hAA, 9'd511, 9'd1});
        send_byte(8'h00, 4'd8);
        send_byte(8'hFF, 4'd8);
        send_byte(8'hA5, 4'd9);
        // Code spanning two bytes
        send_byte(8'h80, 4'd1);
        send_byte(8'h60, 4'd3);
        // Node write in mid-code sends the walk back to the root
        send_byte(8'hC0, 4'd1);
        send_node(2, '{1'b1, 8'h7F, 9'h100, 9'h0FF});
        send_byte(8'h00, 4'd2);
        send_byte(8'h7E, 4'd7);
        send_byte(8'h55, 4'd0);

        // Random trees, each followed by a run of bytes with stray writes
        while (words_sent < TOTAL_WORDS)
        begin
            r = $urandom_range(9, 0);
            if (r == 0)
                leaf_total = 1;
            else if (r < 8)
                leaf_total = $urandom_range(8, 2);
            else
                leaf_total = $urandom_range(24, 9);
            load_tree(leaf_total);
            repeat ($urandom_range(16, 4))
            begin
                if ($urandom_range(9, 0) == 0)
                    send_stray_node();
                else
                    send_byte(8'($urandom_range(255, 0)), random_count());
            end
        end
        start = 1'b0;

        // Drain the remaining symbols, then allow for stragglers
        while (board.owed_symbols.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        board.close_out();
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
